// ----- rtl/tts_pkg.sv -----
// ============================================================================
// tts_pkg
// Shared types and constants for the TAD text to Shift-JIS stream core.
// ============================================================================
package tts_pkg;

  typedef enum logic [4:0] {
    PH_TEXT = 5'b00001,
    PH_LEN  = 5'b00010,
    PH_LOW  = 5'b00100,
    PH_HIGH = 5'b01000,
    PH_BODY = 5'b10000
  } phase_t;

  localparam logic [15:0] SEG_ID_MIN   = 16'hFF00;
  localparam logic [15:0] LEN_ESCAPE   = 16'hFFFF;
  localparam logic [15:0] CHAR_TAB     = 16'h0009;
  localparam logic [15:0] CHAR_LF      = 16'h000A;
  localparam logic [15:0] CHAR_CR      = 16'h000D;
  localparam logic [7:0]  BYTE_TAB     = 8'h09;
  localparam logic [7:0]  BYTE_CR      = 8'h0D;
  localparam logic [7:0]  BYTE_LF      = 8'h0A;
  localparam logic [7:0]  JIS_MIN      = 8'h21;
  localparam logic [7:0]  JIS_MAX      = 8'h7E;
  localparam int          SKIP_W       = 31;

  typedef struct packed {
    logic       emit;
    logic [1:0] byte_count;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } result_t;

endpackage

// ----- rtl/tts_jis2sjis.sv -----
// ============================================================================
// tts_jis2sjis
// Converts one JIS character code to its Shift-JIS byte pair.
// ============================================================================
module tts_jis2sjis (
  input  logic [15:0] jis,
  output logic [7:0]  lead,
  output logic [7:0]  trail
);
  import tts_pkg::*;

  logic [7:0] hi;
  logic [7:0] lo;
  logic       in_range;
  logic [8:0] lo_odd;
  logic [8:0] lo_conv;
  logic [8:0] hi_base;
  logic [8:0] hi_conv;

  assign hi = jis[15:8];
  assign lo = jis[7:0];
  assign in_range = (hi >= JIS_MIN) && (hi <= JIS_MAX) && (lo >= JIS_MIN) && (lo <= JIS_MAX);

  always_comb begin
    lo_odd  = {1'b0, lo} + 9'h01F;
    if (lo_odd >= 9'h07F) begin
      lo_odd = lo_odd + 9'h001;
    end
    lo_conv = hi[0] ? lo_odd : ({1'b0, lo} + 9'h07E);
    hi_base = ({1'b0, hi} + 9'h001) >> 1;
    hi_conv = hi_base + 9'h070;
    if (hi_conv >= 9'h0A0) begin
      hi_conv = hi_conv + 9'h040;
    end
  end

  assign lead  = in_range ? hi_conv[7:0] : 8'h00;
  assign trail = in_range ? lo_conv[7:0] : 8'h00;

endmodule

// ----- rtl/tts_parser.sv -----
// ============================================================================
// tts_parser
// Holds the segment parse state and decodes one word per step into an
// optional result.
// ============================================================================
module tts_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [15:0]      word,
  input  logic             buffer_start,
  output tts_pkg::result_t result
);
  import tts_pkg::*;

  phase_t              phase;
  phase_t              phase_next;
  logic [SKIP_W-1:0]   skip_words_left;
  logic [SKIP_W-1:0]   skip_words_left_next;
  logic [15:0]         length_low_word;
  logic [15:0]         length_low_word_next;
  phase_t              phase_eff;
  logic [SKIP_W-1:0]   skip_dec;
  logic [SKIP_W-1:0]   skip_high;
  logic [SKIP_W-1:0]   skip_len;
  logic [7:0]          sj_lead;
  logic [7:0]          sj_trail;

  tts_jis2sjis u_conv (
    .jis   (word),
    .lead  (sj_lead),
    .trail (sj_trail)
  );

  assign phase_eff = buffer_start ? PH_TEXT : phase;
  assign skip_dec  = skip_words_left - {{(SKIP_W-1){1'b0}}, 1'b1};
  assign skip_high = {word, length_low_word[15:1]};
  assign skip_len  = {{(SKIP_W-15){1'b0}}, word[15:1]};

  always_comb begin
    phase_next           = phase_eff;
    skip_words_left_next = buffer_start ? '0 : skip_words_left;
    length_low_word_next = buffer_start ? '0 : length_low_word;
    result               = '0;
    unique case (phase_eff)
      PH_LEN: begin
        if (word == LEN_ESCAPE) begin
          phase_next = PH_LOW;
        end else begin
          skip_words_left_next = skip_len;
          phase_next = (skip_len != '0) ? PH_BODY : PH_TEXT;
        end
      end
      PH_LOW: begin
        length_low_word_next = word;
        phase_next = PH_HIGH;
      end
      PH_HIGH: begin
        skip_words_left_next = skip_high;
        phase_next = (skip_high != '0) ? PH_BODY : PH_TEXT;
      end
      PH_BODY: begin
        skip_words_left_next = skip_dec;
        phase_next = (skip_dec == '0) ? PH_TEXT : PH_BODY;
      end
      default: begin
        phase_next = PH_TEXT;
        if (word >= SEG_ID_MIN) begin
          phase_next = PH_LEN;
        end else if (word == CHAR_TAB) begin
          result = '{emit: 1'b1, byte_count: 2'd1, first_byte: BYTE_TAB, second_byte: 8'h00};
        end else if (word == CHAR_LF || word == CHAR_CR) begin
          result = '{emit: 1'b1, byte_count: 2'd2, first_byte: BYTE_CR, second_byte: BYTE_LF};
        end else begin
          result = '{emit: 1'b1, byte_count: 2'd2, first_byte: sj_lead, second_byte: sj_trail};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_TEXT;
      skip_words_left <= '0;
      length_low_word <= '0;
    end else if (step) begin
      phase           <= phase_next;
      skip_words_left <= skip_words_left_next;
      length_low_word <= length_low_word_next;
    end
  end

endmodule

// ----- rtl/tad_text_to_sjis_stream_core.sv -----
// ============================================================================
// tad_text_to_sjis_stream_core
// TAD word stream to Shift-JIS byte stream converter with segment skipping.
// ============================================================================
// Each accepted 16-bit word is captured in an input register and decoded from
// there against the segment parse state. A character yields one output word
// of one or two bytes in the result register, while segment ids, lengths and
// body words are consumed silently. One word is accepted per cycle while the
// output is not stalled. A character's word passes the input register and
// then the result register before its bytes are presented. While an output
// word waits, the input register still takes one more word and then holds it
// until the output word is accepted.
module tad_text_to_sjis_stream_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        word_valid,
  output logic        word_ready,
  input  logic [15:0] word,
  input  logic        buffer_start,
  output logic        bytes_valid,
  input  logic        bytes_ready,
  output logic [1:0]  byte_count,
  output logic [7:0]  first_byte,
  output logic [7:0]  second_byte
);
  import tts_pkg::*;

  logic        hold_valid;
  logic [15:0] hold_word;
  logic        hold_start;
  logic        advance;
  result_t     result;

  assign advance    = hold_valid && (!bytes_valid || bytes_ready);
  assign word_ready = !hold_valid || advance;

  tts_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .word         (hold_word),
    .buffer_start (hold_start),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (word_ready) begin
      hold_valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid && word_ready) begin
      hold_word  <= word;
      hold_start <= buffer_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_valid <= 1'b0;
    end else if (advance && result.emit) begin
      bytes_valid <= 1'b1;
    end else if (bytes_ready) begin
      bytes_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      byte_count  <= result.byte_count;
      first_byte  <= result.first_byte;
      second_byte <= result.second_byte;
    end
  end

endmodule

// ----- rtl/tts_checker.sv -----
// ============================================================================
// tts_checker
// Port-level checks for the TAD text to Shift-JIS stream core.
// ============================================================================
module tts_checker (
  input logic        clk,
  input logic        rst,
  input logic        word_valid,
  input logic        word_ready,
  input logic        bytes_valid,
  input logic        bytes_ready,
  input logic [1:0]  byte_count,
  input logic [7:0]  first_byte,
  input logic [7:0]  second_byte
);
  import tts_pkg::*;

  // A stalled output word keeps its bytes.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    bytes_valid && !bytes_ready |=> bytes_valid && $stable(byte_count)
      && $stable(first_byte) && $stable(second_byte))
    else $error("output word changed while stalled");

  // Only a tab produces a single byte, with a zero second byte.
  a_single_tab: assert property (@(posedge clk) disable iff (rst)
    bytes_valid && byte_count != 2'd2 |-> byte_count == 2'd1
      && first_byte == BYTE_TAB && second_byte == 8'h00)
    else $error("bad single-byte output word");

  // A CR is always followed by LF in the same output word.
  a_crlf: assert property (@(posedge clk) disable iff (rst)
    bytes_valid && first_byte == BYTE_CR |-> byte_count == 2'd2 && second_byte == BYTE_LF)
    else $error("CR without LF");

  // A fresh output word follows an accepted input word.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(bytes_valid) |-> $past(word_valid && word_ready, 2))
    else $error("output word without a matching input word");

endmodule

bind tad_text_to_sjis_stream_core tts_checker u_tts_checker (
  .clk         (clk),
  .rst         (rst),
  .word_valid  (word_valid),
  .word_ready  (word_ready),
  .bytes_valid (bytes_valid),
  .bytes_ready (bytes_ready),
  .byte_count  (byte_count),
  .first_byte  (first_byte),
  .second_byte (second_byte)
);

// ----- tb/sjis_stream_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sjis_stream_checker
// Watches both channels of the TAD to Shift-JIS core and checks every output.
// ============================================================================
// Each accepted input word goes through a local copy of the segment parser
// and the JIS to Shift-JIS mapping. Each character queues the byte word that
// the core must produce. Every accepted output word is compared field by
// field with the oldest queued one. The mismatch count, the number of byte
// words still owed and the number checked are handed to the top.
// ============================================================================
module sjis_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        word_valid,
  input  logic        word_ready,
  input  logic [15:0] word,
  input  logic        buffer_start,
  input  logic        bytes_valid,
  input  logic        bytes_ready,
  input  logic [1:0]  byte_count,
  input  logic [7:0]  first_byte,
  input  logic [7:0]  second_byte,
  output int          mismatches,
  output int          backlog,
  output int          checked
);
  import tts_pkg::*;

  typedef struct packed {
    logic [1:0] count;
    logic [7:0] lead;
    logic [7:0] trail;
  } sjis_out_t;

  sjis_out_t   owed_bytes[$];
  phase_t      seg_phase;
  logic [30:0] skip_left;
  logic [15:0] len_low;
  int          err_count;
  int          check_count;

  function automatic logic [15:0] jis_pair_to_sjis(input logic [15:0] c);
    logic [8:0] lead;
    logic [8:0] trail;
    if (c[15:8] < JIS_MIN || c[15:8] > JIS_MAX || c[7:0] < JIS_MIN || c[7:0] > JIS_MAX) begin
      return 16'h0000;
    end
    if (c[8]) begin
      trail = {1'b0, c[7:0]} + 9'h1F;
      if (trail >= 9'h7F) begin
        trail = trail + 9'd1;
      end
    end else begin
      trail = {1'b0, c[7:0]} + 9'h7E;
    end
    lead = (({1'b0, c[15:8]} + 9'd1) >> 1) + 9'h70;
    if (lead >= 9'hA0) begin
      lead = lead + 9'h40;
    end
    return {lead[7:0], trail[7:0]};
  endfunction

  task automatic begin_skip(input logic [31:0] seg_len);
    skip_left = seg_len[31:1];
    seg_phase = (skip_left != '0) ? PH_BODY : PH_TEXT;
  endtask

  task automatic take_word(input logic [15:0] w, input logic bs);
    if (bs) begin
      seg_phase = PH_TEXT;
      skip_left = '0;
      len_low   = '0;
    end
    case (seg_phase)
      PH_LEN: begin
        if (w == LEN_ESCAPE) begin
          seg_phase = PH_LOW;
        end else begin
          begin_skip({16'h0000, w});
        end
      end
      PH_LOW: begin
        len_low   = w;
        seg_phase = PH_HIGH;
      end
      PH_HIGH: begin
        begin_skip({w, len_low});
      end
      PH_BODY: begin
        skip_left = skip_left - 31'd1;
        if (skip_left == '0) begin
          seg_phase = PH_TEXT;
        end
      end
      default: begin
        seg_phase = PH_TEXT;
        if (w >= SEG_ID_MIN) begin
          seg_phase = PH_LEN;
        end else if (w == CHAR_TAB) begin
          owed_bytes.push_back(sjis_out_t'{2'd1, BYTE_TAB, 8'h00});
        end else if (w == CHAR_LF || w == CHAR_CR) begin
          owed_bytes.push_back(sjis_out_t'{2'd2, BYTE_CR, BYTE_LF});
        end else begin
          owed_bytes.push_back(sjis_out_t'({2'd2, jis_pair_to_sjis(w)}));
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    sjis_out_t want;
    if (rst) begin
      owed_bytes.delete();
      seg_phase = PH_TEXT;
      skip_left = '0;
      len_low   = '0;
    end else begin
      if (bytes_valid && bytes_ready) begin
        if (owed_bytes.size() == 0) begin
          $display("%0t: unexpected byte word, count %0d, bytes %02h %02h", $time,
                   byte_count, first_byte, second_byte);
          err_count++;
        end else begin
          want = owed_bytes.pop_front();
          check_count++;
          if (byte_count !== want.count) begin
            $display("%0t: byte_count expected %0d, got %0d", $time, want.count, byte_count);
            err_count++;
          end
          if (first_byte !== want.lead) begin
            $display("%0t: first_byte expected %02h, got %02h", $time, want.lead, first_byte);
            err_count++;
          end
          if (second_byte !== want.trail) begin
            $display("%0t: second_byte expected %02h, got %02h", $time, want.trail,
                     second_byte);
            err_count++;
          end
        end
      end
      if (word_valid && word_ready) begin
        take_word(word, buffer_start);
      end
    end
    mismatches <= err_count;
    backlog    <= owed_bytes.size();
    checked    <= check_count;
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Regression bench for the TAD text to Shift-JIS stream core.
// ============================================================================
// A short directed sequence covers the character extremes, TAB, CR and LF,
// out-of-range JIS bytes, short, empty, escaped and huge segments, and a
// buffer start that abandons a segment. Random records follow: characters,
// complete segments, segments cut off by a new buffer, and loose words,
// under four mixes of sender idling and receiver stalling. The checker
// beside the core predicts and compares; this module gives the verdict.
// ============================================================================
module tb_top;
  import tts_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASE_WORDS   = 425;
  localparam int DRAIN_CYCLES  = 8;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        word_valid   = 1'b0;
  logic [15:0] word         = '0;
  logic        buffer_start = 1'b0;
  logic        bytes_ready  = 1'b0;
  logic        word_ready;
  logic        bytes_valid;
  logic [1:0]  byte_count;
  logic [7:0]  first_byte;
  logic [7:0]  second_byte;

  int mismatches;
  int backlog;
  int checked;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int words_sent      = 0;
  int quiet_cycles    = 0;
  logic restart_next  = 1'b0;

  always #5 clk = ~clk;

  tad_text_to_sjis_stream_core dut (
    .clk          (clk),
    .rst          (rst),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .word         (word),
    .buffer_start (buffer_start),
    .bytes_valid  (bytes_valid),
    .bytes_ready  (bytes_ready),
    .byte_count   (byte_count),
    .first_byte   (first_byte),
    .second_byte  (second_byte)
  );

  sjis_stream_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .word         (word),
    .buffer_start (buffer_start),
    .bytes_valid  (bytes_valid),
    .bytes_ready  (bytes_ready),
    .byte_count   (byte_count),
    .first_byte   (first_byte),
    .second_byte  (second_byte),
    .mismatches   (mismatches),
    .backlog      (backlog),
    .checked      (checked)
  );

  always @(posedge clk) begin
    bytes_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (word_valid && word_ready) || (bytes_valid && bytes_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("tad_text_to_sjis_stream_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_word(input logic [15:0] w, input logic bs);
    while ($urandom_range(99) < sender_idle_pct) begin
      word_valid <= 1'b0;
      @(posedge clk);
    end
    word_valid   <= 1'b1;
    word         <= w;
    buffer_start <= bs;
    @(negedge clk);
    while (!word_ready) begin
      @(negedge clk);
    end
    @(posedge clk);
    words_sent++;
  endtask

  function automatic logic [15:0] random_char();
    case ($urandom_range(9))
      0: return CHAR_TAB;
      1: return CHAR_LF;
      2: return CHAR_CR;
      3: return 16'($urandom_range(32'hFEFF));
      default: return {8'($urandom_range(JIS_MAX, JIS_MIN)), 8'($urandom_range(JIS_MAX, JIS_MIN))};
    endcase
  endfunction

  task automatic send_random_record();
    int unsigned kind;
    int unsigned body_words;
    int unsigned cut_at;
    logic [31:0] seg_len;
    logic [15:0] w;
    logic        bs;
    bs           = restart_next || ($urandom_range(99) < 3);
    restart_next = 1'b0;
    kind         = $urandom_range(99);
    if (kind < 60) begin
      push_word(random_char(), bs);
    end else if (kind < 92) begin
      push_word({8'hFF, 8'($urandom_range(255))}, bs);
      seg_len = ($urandom_range(19) == 0) ? $urandom_range(400) : $urandom_range(40);
      if ($urandom_range(3) == 0) begin
        push_word(LEN_ESCAPE, 1'b0);
        push_word(seg_len[15:0], 1'b0);
        push_word(seg_len[31:16], 1'b0);
      end else begin
        push_word(seg_len[15:0], 1'b0);
      end
      body_words = seg_len >> 1;
      cut_at = ($urandom_range(9) == 0) ? $urandom_range(body_words) : body_words;
      for (int i = 0; i < cut_at; i++) begin
        push_word(16'($urandom()), 1'b0);
      end
      if (cut_at != body_words) begin
        restart_next = 1'b1;
      end
    end else begin
      w = 16'($urandom());
      push_word(w, bs);
      if (w >= SEG_ID_MIN) begin
        restart_next = 1'b1;
      end
    end
  endtask

  initial begin
    logic [16:0] intro[];
    int idle_plan[4];
    int stall_plan[4];
    int target;
    intro = '{
      {1'b1, 16'h0000}, {1'b0, CHAR_TAB}, {1'b0, CHAR_LF}, {1'b0, CHAR_CR},
      {1'b0, 16'h2121}, {1'b0, 16'h7E7E}, {1'b0, 16'h2160}, {1'b0, 16'h5F21},
      {1'b0, 16'h207F}, {1'b0, 16'h7F20}, {1'b0, 16'hFEFF},
      {1'b0, SEG_ID_MIN}, {1'b0, 16'h0000},
      {1'b0, 16'hFF7F}, {1'b0, 16'h0001},
      {1'b0, LEN_ESCAPE}, {1'b0, LEN_ESCAPE}, {1'b0, 16'h0004}, {1'b0, 16'h0000},
      {1'b0, 16'hFF05}, {1'b0, CHAR_CR},
      {1'b0, 16'hFF80}, {1'b0, LEN_ESCAPE}, {1'b0, 16'hFFFF}, {1'b0, 16'hFFFF},
      {1'b0, 16'h2121}, {1'b1, 16'h2422}
    };
    idle_plan  = '{0, 80, 0, 17};
    stall_plan = '{0, 0, 80, 17};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (intro[i]) begin
      push_word(intro[i][15:0], intro[i][16]);
    end

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_plan[ph];
      recv_stall_pct <= stall_plan[ph];
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        send_random_record();
      end
    end

    word_valid     <= 1'b0;
    recv_stall_pct <= 0;
    @(posedge clk);
    while (backlog != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d TAD words under four idle and stall mixes, %0d byte words checked.",
             words_sent, checked);
    if (mismatches == 0 && backlog == 0) begin
      $display("tad_text_to_sjis_stream_core regression: pass");
    end else begin
      $display("tad_text_to_sjis_stream_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tts_pkg.sv
rtl/tts_jis2sjis.sv
rtl/tts_parser.sv
rtl/tad_text_to_sjis_stream_core.sv
rtl/tts_checker.sv
tb/sjis_stream_checker.sv
tb/tb_top.sv
